[src/gqg_pkg.sv]
// ----------------------------------------------------------------------------
// gqg_pkg
// Shared types, codes and helpers for the glyph quad generator.
// ----------------------------------------------------------------------------
package gqg_pkg;

   // Request kinds.
   localparam logic [1:0] KIND_BEGIN = 2'd0;
   localparam logic [1:0] KIND_CHAR  = 2'd1;
   localparam logic [1:0] KIND_TABLE = 2'd2;

   // Glyph table fields; each one is a 16-bit lane of a table entry.
   localparam logic [3:0] FLD_ADVX   = 4'd0;
   localparam logic [3:0] FLD_ADVY   = 4'd1;
   localparam logic [3:0] FLD_WIDTH  = 4'd2;
   localparam logic [3:0] FLD_HEIGHT = 4'd3;
   localparam logic [3:0] FLD_LEFT   = 4'd4;
   localparam logic [3:0] FLD_TOP    = 4'd5;
   localparam logic [3:0] FLD_USTART = 4'd6;
   localparam logic [3:0] FLD_UEND   = 4'd7;
   localparam logic [3:0] FLD_VEND   = 4'd8;

   localparam int LANE_W      = 16;
   localparam int FIELD_COUNT = 9;
   localparam int ENTRY_W     = LANE_W * FIELD_COUNT;

   // Register indexes of the configuration port.
   localparam logic CSR_SCALE_X = 1'b0;
   localparam logic CSR_SCALE_Y = 1'b1;

   localparam logic [31:0] SCALE_ONE = 32'h0001_0000;

   // Product and sum widths of the position arithmetic.
   localparam int SPROD_W = 49;   // signed 16 x unsigned 32
   localparam int PROD_W  = 48;   // unsigned 16 x unsigned 32
   localparam int POS_W   = 50;   // pen plus signed product
   localparam int SUM_W   = 51;   // position plus unsigned product

   // Lane order matches the field codes: advx in the low lane.
   typedef struct packed {
      logic [15:0] v_end;
      logic [15:0] u_end;
      logic [15:0] u_start;
      logic [15:0] top;
      logic [15:0] left;
      logic [15:0] height;
      logic [15:0] width;
      logic [15:0] adv_y;
      logic [15:0] adv_x;
   } glyph_type;

   // Request handed from the front end to the geometry pipeline.
   typedef struct packed {
      logic               load;
      logic               is_begin;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
   } stage_in_type;

   // One quad ready for corner emission.
   typedef struct packed {
      logic signed [POS_W-1:0] left_x;
      logic signed [POS_W-1:0] top_y;
      logic [PROD_W-1:0]       width_x;
      logic [PROD_W-1:0]       height_y;
      logic [15:0]             u_start;
      logic [15:0]             u_end;
      logic [15:0]             v_end;
   } quad_type;

   localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-31){1'b1}}, {31{1'b0}}};

   function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SAT_LO) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[src/gqg_glyph_table.sv]
// ----------------------------------------------------------------------------
// gqg_glyph_table
// Glyph metrics memory with per-field lane writes and a registered read port.
// ----------------------------------------------------------------------------
module gqg_glyph_table #(
   parameter int GLYPH_COUNT = 128,
   parameter int IDX_W       = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  logic [3:0]           wr_field,
   input  logic [15:0]          wr_value,
   input  logic                 rd_en,
   input  logic [IDX_W-1:0]     rd_addr,
   output gqg_pkg::glyph_type   rd_glyph
);
   import gqg_pkg::*;

   logic [ENTRY_W-1:0]     glyph_mem [GLYPH_COUNT];
   logic [GLYPH_COUNT-1:0] valid_ff;
   logic [ENTRY_W-1:0]     rd_data_ff;
   logic                   rd_hit_ff;
   logic [FIELD_COUNT-1:0] lane_we;
   logic [ENTRY_W-1:0]     lane_data;

   // An entry never written reads as zero. Its first write fills every lane,
   // the untouched ones with zero, so later writes need only their own lane.
   always_comb begin
      for (int l = 0; l < FIELD_COUNT; l++) begin
         lane_data[l*LANE_W +: LANE_W] = (wr_field == 4'(l)) ? wr_value : '0;
         lane_we[l] = (wr_field == 4'(l)) || !valid_ff[wr_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int l = 0; l < FIELD_COUNT; l++) begin
            if (lane_we[l]) begin
               glyph_mem[wr_addr][l*LANE_W +: LANE_W] <= lane_data[l*LANE_W +: LANE_W];
            end
         end
      end
      if (rd_en) begin
         rd_data_ff <= glyph_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_glyph = rd_hit_ff ? glyph_type'(rd_data_ff) : '0;

endmodule

[src/gqg_geometry.sv]
// ----------------------------------------------------------------------------
// gqg_geometry
// Scales the glyph metrics, places the quad at the pen and advances the pen.
// ----------------------------------------------------------------------------
module gqg_geometry (
   input  logic                  clock,
   input  logic                  reset,
   input  gqg_pkg::stage_in_type stage_in,
   input  gqg_pkg::glyph_type    glyph,
   input  logic [31:0]           scale_x,
   input  logic [31:0]           scale_y,
   output logic                  req_stall,
   output logic                  quad_valid,
   input  logic                  quad_ready,
   output gqg_pkg::quad_type     quad
);
   import gqg_pkg::*;

   function automatic logic signed [SPROD_W-1:0] mul_su(input logic signed [15:0] a,
                                                        input logic [31:0] b);
      logic signed [32:0] bs;
      bs = $signed({1'b0, b});
      return SPROD_W'(a) * SPROD_W'(bs);
   endfunction

   function automatic logic [PROD_W-1:0] mul_uu(input logic [15:0] a, input logic [31:0] b);
      return PROD_W'(a) * PROD_W'(b);
   endfunction

   // Stage 1: request waits for its table read.
   logic               v1_ff;
   logic               begin1_ff;
   logic signed [31:0] ox1_ff;
   logic signed [31:0] oy1_ff;

   // Stage 2: scaled metrics.
   logic                      v2_ff;
   logic                      begin2_ff;
   logic                      empty2_ff;
   logic signed [31:0]        ox2_ff;
   logic signed [31:0]        oy2_ff;
   logic signed [SPROD_W-1:0] adv_x_ff;
   logic signed [SPROD_W-1:0] adv_y_ff;
   logic signed [SPROD_W-1:0] left_ff;
   logic signed [SPROD_W-1:0] top_ff;
   logic [PROD_W-1:0]         width_ff;
   logic [PROD_W-1:0]         height_ff;
   logic [15:0]               u0_ff;
   logic [15:0]               u1_ff;
   logic [15:0]               v1e_ff;

   logic signed [31:0] pen_x_ff;
   logic signed [31:0] pen_y_ff;
   logic signed [31:0] pen_x_in;
   logic signed [31:0] pen_y_in;

   logic s1_move;
   logic s2_retire;
   logic empty_glyph;

   assign quad_valid = v2_ff && !begin2_ff && !empty2_ff;
   assign s2_retire  = v2_ff && (!quad_valid || quad_ready);
   assign s1_move    = v1_ff && (!v2_ff || s2_retire);
   assign req_stall  = v1_ff && !s1_move;

   assign empty_glyph = (glyph.width == '0) || (glyph.height == '0) ||
                        (scale_x == '0) || (scale_y == '0);

   always_comb begin
      quad.left_x   = POS_W'(pen_x_ff) + POS_W'(left_ff);
      quad.top_y    = POS_W'(pen_y_ff) + POS_W'(top_ff);
      quad.width_x  = width_ff;
      quad.height_y = height_ff;
      quad.u_start  = u0_ff;
      quad.u_end    = u1_ff;
      quad.v_end    = v1e_ff;
      if (begin2_ff) begin
         pen_x_in = ox2_ff;
         pen_y_in = oy2_ff;
      end else begin
         pen_x_in = sat32(SUM_W'(pen_x_ff) + SUM_W'(adv_x_ff));
         pen_y_in = sat32(SUM_W'(pen_y_ff) + SUM_W'(adv_y_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (stage_in.load) begin
         begin1_ff <= stage_in.is_begin;
         ox1_ff    <= stage_in.origin_x;
         oy1_ff    <= stage_in.origin_y;
      end
      if (s1_move) begin
         begin2_ff <= begin1_ff;
         empty2_ff <= empty_glyph;
         ox2_ff    <= ox1_ff;
         oy2_ff    <= oy1_ff;
         adv_x_ff  <= mul_su($signed(glyph.adv_x), scale_x);
         adv_y_ff  <= mul_su($signed(glyph.adv_y), scale_y);
         left_ff   <= mul_su($signed(glyph.left), scale_x);
         top_ff    <= mul_su($signed(glyph.top), scale_y);
         width_ff  <= mul_uu(glyph.width, scale_x);
         height_ff <= mul_uu(glyph.height, scale_y);
         u0_ff     <= glyph.u_start;
         u1_ff     <= glyph.u_end;
         v1e_ff    <= glyph.v_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         pen_x_ff <= '0;
         pen_y_ff <= '0;
      end else begin
         v1_ff <= stage_in.load || (v1_ff && !s1_move);
         v2_ff <= s1_move || (v2_ff && !s2_retire);
         if (s2_retire) begin
            pen_x_ff <= pen_x_in;
            pen_y_ff <= pen_y_in;
         end
      end
   end

   // A request is only held off while the first stage is occupied.
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff)
      else $error("request stalled with an empty first stage");

   // A blocked second stage keeps its item and its products.
   a_stage2_holds: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !s2_retire) |=> (v2_ff && $stable(left_ff) && $stable(adv_x_ff)))
      else $error("second stage lost its item while blocked");

endmodule

[src/gqg_corner_emit.sv]
// ----------------------------------------------------------------------------
// gqg_corner_emit
// Holds one quad and sends its four corners through the response register.
// ----------------------------------------------------------------------------
module gqg_corner_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               quad_valid,
   output logic               quad_ready,
   input  gqg_pkg::quad_type  quad,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_vertex_x,
   output logic signed [31:0] rsp_vertex_y,
   output logic [15:0]        rsp_tex_u,
   output logic [15:0]        rsp_tex_v,
   output logic [1:0]         rsp_corner,
   output logic               rsp_last_corner
);
   import gqg_pkg::*;

   quad_type q_ff;
   logic     qv_ff;
   logic [1:0] cnt_ff;

   logic               rv_ff;
   logic signed [31:0] x_ff;
   logic signed [31:0] y_ff;
   logic [15:0]        u_ff;
   logic [15:0]        v_ff;
   logic [1:0]         corner_ff;
   logic               last_ff;

   logic out_free;
   logic emit;
   logic last_emit;
   logic load;
   logic right;
   logic bottom;
   logic signed [SUM_W-1:0] x_off;
   logic signed [SUM_W-1:0] y_off;
   logic signed [SUM_W-1:0] x_sum;
   logic signed [SUM_W-1:0] y_sum;

   assign out_free   = !rv_ff || !rsp_stall;
   assign emit       = qv_ff && out_free;
   assign last_emit  = emit && (cnt_ff == 2'd3);
   assign quad_ready = !qv_ff || last_emit;
   assign load       = quad_valid && quad_ready;

   // Corner code bit 0 selects the right edge, bit 1 the bottom edge.
   always_comb begin
      right  = cnt_ff[0];
      bottom = cnt_ff[1];
      x_off  = right  ? SUM_W'(q_ff.width_x)  : '0;
      y_off  = bottom ? SUM_W'(q_ff.height_y) : '0;
      x_sum  = SUM_W'(q_ff.left_x) + x_off;
      y_sum  = SUM_W'(q_ff.top_y) - y_off;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         q_ff <= quad;
      end
      if (emit) begin
         x_ff      <= sat32(x_sum);
         y_ff      <= sat32(y_sum);
         u_ff      <= right  ? q_ff.u_end : q_ff.u_start;
         v_ff      <= bottom ? q_ff.v_end : '0;
         corner_ff <= cnt_ff;
         last_ff   <= (cnt_ff == 2'd3);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qv_ff  <= 1'b0;
         cnt_ff <= '0;
         rv_ff  <= 1'b0;
      end else begin
         if (load) begin
            qv_ff  <= 1'b1;
            cnt_ff <= '0;
         end else begin
            if (last_emit) begin
               qv_ff <= 1'b0;
            end
            if (emit) begin
               cnt_ff <= cnt_ff + 2'd1;
            end
         end
         if (emit) begin
            rv_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rv_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rv_ff;
   assign rsp_vertex_x    = x_ff;
   assign rsp_vertex_y    = y_ff;
   assign rsp_tex_u       = u_ff;
   assign rsp_tex_v       = v_ff;
   assign rsp_corner      = corner_ff;
   assign rsp_last_corner = last_ff;

   // The corner counter only runs while a quad is held.
   a_count_has_quad: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != 2'd0) |-> qv_ff)
      else $error("corner counter running without a quad");

   // A quad stays until its bottom-right corner has gone out.
   a_quad_stays: assert property (@(posedge clock) disable iff (reset)
      (emit && (cnt_ff != 2'd3)) |=> qv_ff)
      else $error("quad dropped before its last corner");

endmodule

[src/glyph_quad_generator_top.sv]
// ----------------------------------------------------------------------------
// glyph_quad_generator_top
// Character stream to textured quad corners, with a loadable glyph table.
// ----------------------------------------------------------------------------
// Path: a character's first corner goes through the table read, the multiply,
// the place and the response register; the other corners follow one per cycle
// while rsp_stall is low. Throughput: one request per cycle while req_stall is
// low; a drawn glyph holds the corner stage until its four corners are out.
// Reset: pen to zero, scales to 1.0, every table entry reads as zero through
// its valid bit; no clearing pass is needed.
module glyph_quad_generator_top #(
   parameter int GLYPH_COUNT = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [6:0]         req_char_code,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic [3:0]         req_table_field,
   input  logic signed [16:0] req_table_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_vertex_x,
   output logic signed [31:0] rsp_vertex_y,
   output logic [15:0]        rsp_tex_u,
   output logic [15:0]        rsp_tex_v,
   output logic [1:0]         rsp_corner,
   output logic               rsp_last_corner,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [31:0]        csr_wdata
);
   import gqg_pkg::*;

   localparam int IDX_W  = $clog2(GLYPH_COUNT);
   localparam int WIDE_W = IDX_W + 7;

   logic [31:0] scale_x_ff;
   logic [31:0] scale_y_ff;

   logic             accept;
   logic [WIDE_W-1:0] code_wide;
   logic             in_range;
   logic [IDX_W-1:0] glyph_addr;
   logic             tbl_wr;
   stage_in_type     stage_in;
   glyph_type        glyph;
   logic             quad_valid;
   logic             quad_ready;
   quad_type         quad;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff <= SCALE_ONE;
         scale_y_ff <= SCALE_ONE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SCALE_X: scale_x_ff <= csr_wdata;
            CSR_SCALE_Y: scale_y_ff <= csr_wdata;
         endcase
      end
   end

   assign accept     = req_valid && !req_stall;
   assign code_wide  = {{IDX_W{1'b0}}, req_char_code};
   assign in_range   = code_wide < WIDE_W'(GLYPH_COUNT);
   assign glyph_addr = code_wide[IDX_W-1:0];

   // Table writes land at once; begin and in-range characters enter the pipe.
   assign tbl_wr = accept && (req_kind == KIND_TABLE) && in_range &&
                   (req_table_field <= FLD_VEND);

   always_comb begin
      stage_in.load     = accept && ((req_kind == KIND_BEGIN) ||
                                     ((req_kind == KIND_CHAR) && in_range));
      stage_in.is_begin = (req_kind == KIND_BEGIN);
      stage_in.origin_x = req_origin_x;
      stage_in.origin_y = req_origin_y;
   end

   gqg_glyph_table #(
      .GLYPH_COUNT(GLYPH_COUNT),
      .IDX_W      (IDX_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tbl_wr),
      .wr_addr (glyph_addr),
      .wr_field(req_table_field),
      .wr_value(req_table_value[15:0]),
      .rd_en   (accept),
      .rd_addr (glyph_addr),
      .rd_glyph(glyph)
   );

   gqg_geometry u_geometry (
      .clock     (clock),
      .reset     (reset),
      .stage_in  (stage_in),
      .glyph     (glyph),
      .scale_x   (scale_x_ff),
      .scale_y   (scale_y_ff),
      .req_stall (req_stall),
      .quad_valid(quad_valid),
      .quad_ready(quad_ready),
      .quad      (quad)
   );

   gqg_corner_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .quad_valid     (quad_valid),
      .quad_ready     (quad_ready),
      .quad           (quad),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_vertex_x   (rsp_vertex_x),
      .rsp_vertex_y   (rsp_vertex_y),
      .rsp_tex_u      (rsp_tex_u),
      .rsp_tex_v      (rsp_tex_v),
      .rsp_corner     (rsp_corner),
      .rsp_last_corner(rsp_last_corner)
   );

endmodule

[tb/glyph_quad_generator_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_quad_generator_top_tb
// Self-checking bench for the glyph quad generator. A queue of requests feeds
// a clocked driver, and a clocked monitor predicts every quad corner from its
// own copy of the pen, glyph table and scales. Each corner that comes out is
// compared in order against those predictions. The scales are changed between
// phases while the block is idle. Both handshakes are throttled at random.
// ----------------------------------------------------------------------------
module glyph_quad_generator_top_tb;
   import gqg_pkg::*;

   localparam int      CLK_PERIOD     = 10;
   localparam int      RESET_CYCLES   = 6;
   localparam int      SETTLE_CYCLES  = 8;
   localparam int      WATCHDOG_LIMIT = 2000;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam longint  POS_MAX        = 64'sd2147483647;
   localparam longint  POS_MIN        = -64'sd2147483648;

   typedef struct {
      logic [1:0]         kind;
      logic [6:0]         code;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic [3:0]         tbl_field;
      logic signed [16:0] tbl_value;
   } glyph_req_type;

   typedef struct packed {
      logic signed [31:0] vertex_x;
      logic signed [31:0] vertex_y;
      logic [15:0]        tex_u;
      logic [15:0]        tex_v;
      logic [1:0]         corner;
      logic               last_corner;
   } corner_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_kind = KIND_BEGIN;
   logic [6:0]         req_char_code = '0;
   logic signed [31:0] req_origin_x = '0;
   logic signed [31:0] req_origin_y = '0;
   logic [3:0]         req_table_field = FLD_ADVX;
   logic signed [16:0] req_table_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_vertex_x;
   logic signed [31:0] rsp_vertex_y;
   logic [15:0]        rsp_tex_u;
   logic [15:0]        rsp_tex_v;
   logic [1:0]         rsp_corner;
   logic               rsp_last_corner;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic               csr_index = CSR_SCALE_X;
   logic [31:0]        csr_wdata = '0;

   // Model state of the block.
   logic signed [31:0] pen_x;
   logic signed [31:0] pen_y;
   logic [31:0]        scale_x_q;
   logic [31:0]        scale_y_q;
   glyph_type          glyph_tab [128];

   glyph_req_type glyph_reqs_pending [$];
   corner_type    expected_corners [$];
   glyph_req_type next_req;
   corner_type    seen_corner;
   corner_type    want_corner;

   logic req_fire = 1'b0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   reqs_queued = 0;
   int   reqs_accepted = 0;
   int   csr_writes_done = 0;
   int   quiet_cycles = 0;
   int   error_count = 0;
   int   chars_seen = 0;
   int   tables_seen = 0;
   int   begins_seen = 0;
   int   ignored_seen = 0;
   int   corners_checked = 0;

   glyph_quad_generator_top #(
      .GLYPH_COUNT(128)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_char_code   (req_char_code),
      .req_origin_x    (req_origin_x),
      .req_origin_y    (req_origin_y),
      .req_table_field (req_table_field),
      .req_table_value (req_table_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_vertex_x    (rsp_vertex_x),
      .rsp_vertex_y    (rsp_vertex_y),
      .rsp_tex_u       (rsp_tex_u),
      .rsp_tex_v       (rsp_tex_v),
      .rsp_corner      (rsp_corner),
      .rsp_last_corner (rsp_last_corner),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > POS_MAX) begin
         return 32'sh7FFF_FFFF;
      end else if (v < POS_MIN) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // Updates the model for one accepted request and queues the corners it draws.
   task automatic predict_corners(input glyph_req_type r);
      glyph_type  g;
      corner_type c;
      longint     sxs, sys, px, py, xl, yt, w, h;
      g = glyph_tab[r.code];
      case (r.kind)
         KIND_BEGIN: begin
            pen_x = r.origin_x;
            pen_y = r.origin_y;
         end
         KIND_TABLE: begin
            case (r.tbl_field)
               FLD_ADVX:   glyph_tab[r.code].adv_x   = r.tbl_value[15:0];
               FLD_ADVY:   glyph_tab[r.code].adv_y   = r.tbl_value[15:0];
               FLD_WIDTH:  glyph_tab[r.code].width   = r.tbl_value[15:0];
               FLD_HEIGHT: glyph_tab[r.code].height  = r.tbl_value[15:0];
               FLD_LEFT:   glyph_tab[r.code].left    = r.tbl_value[15:0];
               FLD_TOP:    glyph_tab[r.code].top     = r.tbl_value[15:0];
               FLD_USTART: glyph_tab[r.code].u_start = r.tbl_value[15:0];
               FLD_UEND:   glyph_tab[r.code].u_end   = r.tbl_value[15:0];
               FLD_VEND:   glyph_tab[r.code].v_end   = r.tbl_value[15:0];
               default: ;
            endcase
         end
         KIND_CHAR: begin
            sxs = longint'({32'd0, scale_x_q});
            sys = longint'({32'd0, scale_y_q});
            px  = longint'(pen_x);
            py  = longint'(pen_y);
            xl  = px + longint'($signed(g.left)) * sxs;
            yt  = py + longint'($signed(g.top)) * sys;
            w   = longint'({48'd0, g.width}) * sxs;
            h   = longint'({48'd0, g.height}) * sys;
            pen_x = clamp32(px + longint'($signed(g.adv_x)) * sxs);
            pen_y = clamp32(py + longint'($signed(g.adv_y)) * sys);
            // A glyph that scales to nothing still moves the pen.
            if (w != 0 && h != 0) begin
               for (int k = 0; k < 4; k++) begin
                  c.vertex_x    = clamp32(k[0] ? xl + w : xl);
                  c.vertex_y    = clamp32(k[1] ? yt - h : yt);
                  c.tex_u       = k[0] ? g.u_end : g.u_start;
                  c.tex_v       = k[1] ? g.v_end : 16'd0;
                  c.corner      = 2'(k);
                  c.last_corner = (k == 3);
                  expected_corners = {expected_corners, c};
               end
            end
         end
         default: ;
      endcase
   endtask

   // Monitor: predicts on accepted requests and checks accepted corners.
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
         pen_x = '0;
         pen_y = '0;
         scale_x_q = SCALE_ONE;
         scale_y_q = SCALE_ONE;
         foreach (glyph_tab[i]) glyph_tab[i] = '0;
      end else begin
         req_fire <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            seen_corner = '{rsp_vertex_x, rsp_vertex_y, rsp_tex_u, rsp_tex_v,
                            rsp_corner, rsp_last_corner};
            if (expected_corners.size() == 0) begin
               $display("%0t: corner %0d arrived with nothing expected", $time, rsp_corner);
               error_count++;
            end else begin
               want_corner = expected_corners.pop_front();
               corners_checked++;
               if (seen_corner != want_corner) begin
                  $display("%0t: corner mismatch, expected x=%0d y=%0d u=%0d v=%0d c=%0d l=%0d",
                           $time, want_corner.vertex_x, want_corner.vertex_y,
                           want_corner.tex_u, want_corner.tex_v, want_corner.corner,
                           want_corner.last_corner);
                  $display("%0t:                    actual x=%0d y=%0d u=%0d v=%0d c=%0d l=%0d",
                           $time, seen_corner.vertex_x, seen_corner.vertex_y,
                           seen_corner.tex_u, seen_corner.tex_v, seen_corner.corner,
                           seen_corner.last_corner);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_corners('{req_kind, req_char_code, req_origin_x, req_origin_y,
                              req_table_field, req_table_value});
            reqs_accepted++;
            case (req_kind)
               KIND_BEGIN: begins_seen++;
               KIND_CHAR:  chars_seen++;
               KIND_TABLE: tables_seen++;
               default:    ignored_seen++;
            endcase
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SCALE_X) begin
               scale_x_q = csr_wdata;
            end else begin
               scale_y_q = csr_wdata;
            end
            csr_writes_done++;
         end
      end
   end

   // Driver: holds a request until it is taken, then may idle before the next one.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_fire) begin
            if (glyph_reqs_pending.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               next_req = glyph_reqs_pending.pop_front();
               req_valid       <= 1'b1;
               req_kind        <= next_req.kind;
               req_char_code   <= next_req.code;
               req_origin_x    <= next_req.origin_x;
               req_origin_y    <= next_req.origin_y;
               req_table_field <= next_req.tbl_field;
               req_table_value <= next_req.tbl_value;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99, 0) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || req_valid && !req_stall || rsp_valid && !rsp_stall ||
          csr_valid && csr_ready) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles at %0t", quiet_cycles, $time);
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic glyph_req_type begin_req(input logic signed [31:0] ox,
                                               input logic signed [31:0] oy);
      return '{KIND_BEGIN, 7'($urandom), ox, oy, 4'($urandom), 17'($urandom)};
   endfunction

   function automatic glyph_req_type table_req(input logic [6:0] code,
                                               input logic [3:0] fld,
                                               input logic signed [16:0] val);
      return '{KIND_TABLE, code, 32'($urandom), 32'($urandom), fld, val};
   endfunction

   function automatic glyph_req_type char_req(input logic [6:0] code);
      return '{KIND_CHAR, code, 32'($urandom), 32'($urandom), 4'($urandom), 17'($urandom)};
   endfunction

   // Mostly a small set of codes so that characters hit loaded glyphs.
   function automatic logic [6:0] pick_code();
      return ($urandom_range(4, 0) == 0) ? 7'($urandom_range(127, 0))
                                        : 7'($urandom_range(15, 0));
   endfunction

   task automatic queue_req(input glyph_req_type r);
      glyph_reqs_pending = {glyph_reqs_pending, r};
      reqs_queued++;
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      @(posedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] data);
      int done_goal;
      done_goal = csr_writes_done + 1;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(negedge clock); while (csr_writes_done != done_goal);
      csr_valid <= 1'b0;
   endtask

   // Waits until every request is taken and every corner has come out, then
   // lets the pipeline empty out after requests that draw nothing.
   task automatic wait_drained();
      do @(negedge clock); while (reqs_accepted != reqs_queued || expected_corners.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_directed();
      queue_req(char_req(7'd0));
      queue_req(table_req(7'd1, FLD_ADVX, 17'sd9));
      queue_req(table_req(7'd1, FLD_ADVY, 17'sd0));
      queue_req(table_req(7'd1, FLD_WIDTH, 17'sd8));
      queue_req(table_req(7'd1, FLD_HEIGHT, 17'sd12));
      queue_req(table_req(7'd1, FLD_LEFT, -17'sd2));
      queue_req(table_req(7'd1, FLD_TOP, 17'sd10));
      queue_req(table_req(7'd1, FLD_USTART, 17'sd0));
      queue_req(table_req(7'd1, FLD_UEND, 17'sd65535));
      queue_req(table_req(7'd1, FLD_VEND, 17'sh0_8000));
      // Pen near both ends of the range, so corners and the advance clamp.
      queue_req(begin_req(32'sh7FFF_0000, 32'sh8000_0000));
      queue_req(char_req(7'd1));
      queue_req(table_req(7'd1, 4'd12, 17'sh1_2345));
      queue_req('{KIND_UNUSED, 7'd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, FLD_WIDTH, -17'sd1});
      queue_req(begin_req(32'sd0, 32'sd0));
      queue_req(char_req(7'd1));
      // Zero width glyph: nothing drawn, pen moves back by the full negative advance.
      queue_req(table_req(7'd2, FLD_HEIGHT, 17'sd5));
      queue_req(table_req(7'd2, FLD_ADVX, -17'sd32768));
      queue_req(char_req(7'd2));
      queue_req(char_req(7'd1));
      // Widest glyph, with a negative value read back as an unsigned height.
      queue_req(table_req(7'd127, FLD_WIDTH, 17'sd65535));
      queue_req(table_req(7'd127, FLD_HEIGHT, -17'sd32768));
      queue_req(table_req(7'd127, FLD_LEFT, 17'sd32767));
      queue_req(table_req(7'd127, FLD_TOP, -17'sd32768));
      queue_req(char_req(7'd127));
   endtask

   task automatic load_random(input int count);
      int                 sel;
      logic [3:0]         fld;
      logic signed [16:0] val;
      logic signed [31:0] ox, oy;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(99, 0);
         if (sel < 8) begin
            if ($urandom_range(3, 0) == 0) begin
               ox = 32'($urandom);
               oy = 32'($urandom);
            end else begin
               ox = 32'($urandom_range(32'h0100_0000, 0)) - 32'sh0080_0000;
               oy = 32'($urandom_range(32'h0100_0000, 0)) - 32'sh0080_0000;
            end
            queue_req(begin_req(ox, oy));
         end else if (sel < 38) begin
            fld = ($urandom_range(9, 0) == 0) ? 4'($urandom_range(15, FIELD_COUNT))
                                              : 4'($urandom_range(FIELD_COUNT - 1, 0));
            if ($urandom_range(4, 0) == 0) begin
               val = 17'($urandom);
            end else if (fld == FLD_WIDTH || fld == FLD_HEIGHT) begin
               val = 17'($urandom_range(40, 0));
            end else if (fld >= FLD_USTART && fld <= FLD_VEND) begin
               val = 17'($urandom_range(65535, 0));
            end else begin
               val = 17'($urandom_range(40, 0)) - 17'sd20;
            end
            queue_req(table_req(pick_code(), fld, val));
         end else if (sel < 96) begin
            queue_req(char_req(pick_code()));
         end else begin
            queue_req('{KIND_UNUSED, 7'($urandom), 32'($urandom), 32'($urandom),
                        4'($urandom), 17'($urandom)});
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_idling(36, 64);
      load_directed();
      wait_drained();

      write_csr(CSR_SCALE_X, 32'hFFFF_FFFF);
      write_csr(CSR_SCALE_Y, 32'hFFFF_FFFF);
      set_idling(36, 64);
      load_random(90);
      wait_drained();

      write_csr(CSR_SCALE_X, 32'h0000_0000);
      write_csr(CSR_SCALE_Y, 32'($urandom_range(32'h0002_0000, 32'h0000_8000)));
      set_idling(64, 36);
      load_random(40);
      wait_drained();

      write_csr(CSR_SCALE_X, 32'($urandom_range(32'h0003_0000, 32'h0000_4000)));
      write_csr(CSR_SCALE_Y, 32'($urandom_range(32'h0003_0000, 32'h0000_4000)));
      set_idling(64, 36);
      load_random(115);
      wait_drained();

      write_csr(CSR_SCALE_X, SCALE_ONE);
      write_csr(CSR_SCALE_Y, SCALE_ONE);
      set_idling(0, 0);
      load_random(115);
      wait_drained();

      if (expected_corners.size() != 0) begin
         $display("%0t: %0d corners never arrived", $time, expected_corners.size());
         error_count++;
      end
      $display("Sent %0d requests: %0d characters, %0d table writes, %0d begins, %0d unused.",
               reqs_accepted, chars_seen, tables_seen, begins_seen, ignored_seen);
      $display("Checked %0d corners over %0d scale register writes; %0d errors.",
               corners_checked, csr_writes_done, error_count);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
